// ===== hw/rtl/wsfd_pkg.sv =====
// shared constants and the utf-8 step function for the websocket deframer
package wsfd_pkg;

  // parse phases
  localparam logic [2:0] PH_HDR1    = 3'd0;
  localparam logic [2:0] PH_HDR2    = 3'd1;
  localparam logic [2:0] PH_EXT16   = 3'd2;
  localparam logic [2:0] PH_EXT64   = 3'd3;
  localparam logic [2:0] PH_KEY     = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  // utf-8 validator states
  localparam logic [3:0] U_NONE  = 4'd0;
  localparam logic [3:0] U_CHAR  = 4'd1;
  localparam logic [3:0] U_TAIL  = 4'd2;
  localparam logic [3:0] U_TAIL2 = 4'd3;
  localparam logic [3:0] U_TAIL3 = 4'd4;
  localparam logic [3:0] U_E0    = 4'd5;
  localparam logic [3:0] U_ED    = 4'd6;
  localparam logic [3:0] U_F0    = 4'd7;
  localparam logic [3:0] U_F4    = 4'd8;
  localparam logic [3:0] U_BAD   = 4'd15;

  // result status codes
  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_HDR     = 3'd1;
  localparam logic [2:0] ST_DONE    = 3'd2;
  localparam logic [2:0] ST_BADOP   = 3'd3;
  localparam logic [2:0] ST_BADUTF  = 3'd4;
  localparam logic [2:0] ST_CTLLONG = 3'd5;
  localparam logic [2:0] ST_HALTED  = 3'd6;

  // opcodes
  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam logic [3:0] OP_PONG   = 4'd10;

  // 7-bit length escapes and the ping limit
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam int unsigned PING_MAX   = 125;
  localparam int unsigned LEN_W      = 63;

  typedef logic [LEN_W-1:0] len_t;

  function automatic logic [3:0] utf8_next(input logic [3:0] st, input logic [7:0] c);
    logic [3:0] nx;
    nx = U_BAD;
    case (st)
      U_NONE: nx = U_NONE;
      U_CHAR: begin
        if (c inside {[8'h00:8'h7F]}) nx = U_CHAR;
        else if (c inside {[8'hC2:8'hDF]}) nx = U_TAIL;
        else if (c == 8'hE0) nx = U_E0;
        else if (c inside {[8'hE1:8'hEC], [8'hEE:8'hEF]}) nx = U_TAIL2;
        else if (c == 8'hED) nx = U_ED;
        else if (c == 8'hF0) nx = U_F0;
        else if (c inside {[8'hF1:8'hF3]}) nx = U_TAIL3;
        else if (c == 8'hF4) nx = U_F4;
        else nx = U_BAD;
      end
      U_E0:    nx = (c inside {[8'hA0:8'hBF]}) ? U_TAIL : U_BAD;
      U_ED:    nx = (c inside {[8'h80:8'h9F]}) ? U_TAIL : U_BAD;
      U_F0:    nx = (c inside {[8'h90:8'hBF]}) ? U_TAIL2 : U_BAD;
      U_F4:    nx = (c inside {[8'h80:8'h8F]}) ? U_TAIL2 : U_BAD;
      U_TAIL:  nx = (c inside {[8'h80:8'hBF]}) ? U_CHAR : U_BAD;
      U_TAIL2: nx = (c inside {[8'h80:8'hBF]}) ? U_TAIL : U_BAD;
      U_TAIL3: nx = (c inside {[8'h80:8'hBF]}) ? U_TAIL2 : U_BAD;
      default: nx = U_BAD;
    endcase
    return nx;
  endfunction

endpackage

// ===== hw/rtl/websocket_frame_deframer_core.sv =====
// websocket frame deframer: header parse, unmasking and utf-8 check, one byte per cycle while results are taken
//
// input channel: in_valid/in_ready carry one raw stream byte (in_byte) per item.
// result channel: out_valid/out_ready carry exactly one result item per input
// item: the unmasked payload byte with its valid flag, the last-of-frame flag,
// the current frame's opcode, fin, rsv bits and decoded length, and a status
// code (busy, header done, frame done, the three errors, halted).
// each byte is processed in the cycle it is accepted and the result lands in
// the output register, so throughput is 1 item per cycle while the receiver
// takes results; the rate is set by the single parse/unmask/validate step per byte.
// a bad opcode, bad utf-8 or a ping longer than 125 bytes halts the block:
// every later item then reports status halted until reset.
// reset (rst_n low at a clock edge) returns the parser to the first header
// byte and clears the output valid flag.
// when the receiver stalls, the pending result holds in the output register
// and in_ready drops; in_ready is high whenever the output register is empty
// or being taken in the same cycle.
module websocket_frame_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_payload_valid,
  output logic        out_last_of_frame,
  output logic [3:0]  out_frame_kind,
  output logic        out_final_flag,
  output logic [2:0]  out_reserved_bits,
  output logic [62:0] out_frame_length,
  output logic [2:0]  out_status
);

  // parser state
  logic [2:0]      phase_r, phase_nxt;
  logic [3:0]      opcode_r, opcode_nxt;
  logic            fin_r, fin_nxt;
  logic [2:0]      rsv_r, rsv_nxt;
  logic            masked_r, masked_nxt;
  wsfd_pkg::len_t  length_r, length_nxt;
  logic [2:0]      hbc_r, hbc_nxt;
  logic [31:0]     mask_key_r, mask_key_nxt;
  wsfd_pkg::len_t  remaining_r, remaining_nxt;
  logic [1:0]      key_index_r, key_index_nxt;
  logic [3:0]      utf8_expect_r, utf8_expect_nxt;
  logic [3:0]      msg_utf8_r, msg_utf8_nxt;
  logic            halted_r, halted_nxt;

  // output register
  logic            out_valid_r;
  logic [7:0]      out_byte_r;
  logic            out_pvalid_r;
  logic            out_last_r;
  logic [2:0]      out_status_r;

  // per-byte results
  logic [7:0]      res_byte;
  logic            res_valid;
  logic            res_last;
  logic [2:0]      res_status;

  logic            accept;
  logic            is_data;
  logic            do_after_len;
  logic            do_hdr_done;
  logic            do_end;
  logic [2:0]      need;
  logic [7:0]      plain;
  logic [7:0]      key_byte;
  logic [3:0]      utf8_nx;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_data  = (opcode_r <= wsfd_pkg::OP_BINARY);
  assign key_byte = mask_key_r[{key_index_r, 3'b000} +: 8];
  assign plain    = masked_r ? (in_byte ^ key_byte) : in_byte;
  assign utf8_nx  = wsfd_pkg::utf8_next(utf8_expect_r, plain);
  assign need     = (phase_r == wsfd_pkg::PH_EXT16) ? 3'd2 : 3'd0;  // 8 wraps to 0

  always_comb begin
    phase_nxt       = phase_r;
    opcode_nxt      = opcode_r;
    fin_nxt         = fin_r;
    rsv_nxt         = rsv_r;
    masked_nxt      = masked_r;
    length_nxt      = length_r;
    hbc_nxt         = hbc_r;
    mask_key_nxt    = mask_key_r;
    remaining_nxt   = remaining_r;
    key_index_nxt   = key_index_r;
    utf8_expect_nxt = utf8_expect_r;
    msg_utf8_nxt    = msg_utf8_r;
    halted_nxt      = halted_r;
    res_byte        = 8'd0;
    res_valid       = 1'b0;
    res_last        = 1'b0;
    res_status      = wsfd_pkg::ST_BUSY;
    do_after_len    = 1'b0;
    do_hdr_done     = 1'b0;
    do_end          = 1'b0;

    if (halted_r) begin
      res_status = wsfd_pkg::ST_HALTED;
    end else begin
      case (phase_r)
        wsfd_pkg::PH_HDR1: begin
          opcode_nxt = in_byte[3:0];
          rsv_nxt    = in_byte[6:4];
          fin_nxt    = in_byte[7];
          if (in_byte[3:0] inside {wsfd_pkg::OP_CONT, wsfd_pkg::OP_TEXT,
                                   wsfd_pkg::OP_BINARY, wsfd_pkg::OP_CLOSE,
                                   wsfd_pkg::OP_PING, wsfd_pkg::OP_PONG}) begin
            phase_nxt = wsfd_pkg::PH_HDR2;
          end else begin
            halted_nxt = 1'b1;
            res_status = wsfd_pkg::ST_BADOP;
          end
        end
        wsfd_pkg::PH_HDR2: begin
          masked_nxt = in_byte[7];
          length_nxt = '0;
          hbc_nxt    = 3'd0;
          if (in_byte[6:0] == wsfd_pkg::LEN_EXT16) begin
            phase_nxt = wsfd_pkg::PH_EXT16;
          end else if (in_byte[6:0] == wsfd_pkg::LEN_EXT64) begin
            phase_nxt = wsfd_pkg::PH_EXT64;
          end else begin
            length_nxt   = wsfd_pkg::len_t'(in_byte[6:0]);
            do_after_len = 1'b1;
          end
        end
        wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64: begin
          // the top bit of a 64-bit length falls off the end
          length_nxt = {length_r[wsfd_pkg::LEN_W-9:0], in_byte};
          hbc_nxt    = hbc_r + 3'd1;
          if (hbc_nxt == need) do_after_len = 1'b1;
        end
        wsfd_pkg::PH_KEY: begin
          mask_key_nxt[{hbc_r[1:0], 3'b000} +: 8] = in_byte;
          hbc_nxt = hbc_r + 3'd1;
          if (hbc_nxt[2]) begin
            hbc_nxt     = 3'd0;
            do_hdr_done = 1'b1;
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          key_index_nxt = key_index_r + 2'd1;
          if (is_data && utf8_nx == wsfd_pkg::U_BAD) begin
            halted_nxt = 1'b1;
            res_status = wsfd_pkg::ST_BADUTF;
          end else begin
            if (is_data) utf8_expect_nxt = utf8_nx;
            if (is_data || opcode_r == wsfd_pkg::OP_PING) begin
              res_byte  = plain;
              res_valid = 1'b1;
            end
            remaining_nxt = remaining_r - wsfd_pkg::len_t'(1);
            if (remaining_nxt == '0) do_end = 1'b1;
          end
        end
        default: phase_nxt = wsfd_pkg::PH_HDR1;
      endcase

      if (do_after_len) begin
        hbc_nxt = 3'd0;
        if (masked_nxt) begin
          mask_key_nxt = '0;
          phase_nxt    = wsfd_pkg::PH_KEY;
        end else begin
          do_hdr_done = 1'b1;
        end
      end

      if (do_hdr_done) begin
        if (opcode_r == wsfd_pkg::OP_PING &&
            length_nxt > wsfd_pkg::len_t'(wsfd_pkg::PING_MAX)) begin
          halted_nxt = 1'b1;
          res_status = wsfd_pkg::ST_CTLLONG;
        end else begin
          if (is_data) begin
            if (opcode_r == wsfd_pkg::OP_TEXT) utf8_expect_nxt = wsfd_pkg::U_CHAR;
            else if (opcode_r == wsfd_pkg::OP_BINARY) utf8_expect_nxt = wsfd_pkg::U_NONE;
            else utf8_expect_nxt = msg_utf8_r;
          end
          if (length_nxt == '0) begin
            do_end = 1'b1;
          end else begin
            remaining_nxt = length_nxt;
            key_index_nxt = 2'd0;
            phase_nxt     = wsfd_pkg::PH_PAYLOAD;
            res_status    = wsfd_pkg::ST_HDR;
          end
        end
      end

      if (do_end) begin
        phase_nxt = wsfd_pkg::PH_HDR1;
        // a final data frame must stop on a character boundary
        if (is_data && fin_r && utf8_expect_nxt != wsfd_pkg::U_NONE &&
            utf8_expect_nxt != wsfd_pkg::U_CHAR) begin
          halted_nxt = 1'b1;
          res_status = wsfd_pkg::ST_BADUTF;
          res_byte   = 8'd0;
          res_valid  = 1'b0;
        end else begin
          if (is_data) msg_utf8_nxt = utf8_expect_nxt;
          res_status = wsfd_pkg::ST_DONE;
          res_last   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= wsfd_pkg::PH_HDR1;
      opcode_r      <= 4'd0;
      fin_r         <= 1'b0;
      rsv_r         <= 3'd0;
      masked_r      <= 1'b0;
      length_r      <= '0;
      hbc_r         <= 3'd0;
      mask_key_r    <= 32'd0;
      remaining_r   <= '0;
      key_index_r   <= 2'd0;
      utf8_expect_r <= wsfd_pkg::U_NONE;
      msg_utf8_r    <= wsfd_pkg::U_NONE;
      halted_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        phase_r       <= phase_nxt;
        opcode_r      <= opcode_nxt;
        fin_r         <= fin_nxt;
        rsv_r         <= rsv_nxt;
        masked_r      <= masked_nxt;
        length_r      <= length_nxt;
        hbc_r         <= hbc_nxt;
        mask_key_r    <= mask_key_nxt;
        remaining_r   <= remaining_nxt;
        key_index_r   <= key_index_nxt;
        utf8_expect_r <= utf8_expect_nxt;
        msg_utf8_r    <= msg_utf8_nxt;
        halted_r      <= halted_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte_r   <= res_byte;
      out_pvalid_r <= res_valid;
      out_last_r   <= res_last;
      out_status_r <= res_status;
    end
  end

  // header fields are the state itself, which only moves on accept
  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_payload_valid = out_pvalid_r;
  assign out_last_of_frame = out_last_r;
  assign out_frame_kind    = opcode_r;
  assign out_final_flag    = fin_r;
  assign out_reserved_bits = rsv_r;
  assign out_frame_length  = length_r;
  assign out_status        = out_status_r;

endmodule

// ===== hw/rtl/wsfd_checker.sv =====
// port-level checks for the websocket deframer, bound to the top level
module wsfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_payload_valid,
  input logic        out_last_of_frame,
  input logic [2:0]  out_status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_status))
    else $error("result changed while stalled");

  // payload bytes only come with busy or frame-done status
  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |->
      out_status == wsfd_pkg::ST_BUSY || out_status == wsfd_pkg::ST_DONE)
    else $error("payload item with header or error status");

  // last flag marks a completed frame
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_frame |-> out_status == wsfd_pkg::ST_DONE)
    else $error("last flag without frame done");

  // no data and no last flag once halted or on an error item
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == wsfd_pkg::ST_HALTED || out_status == wsfd_pkg::ST_BADOP ||
                  out_status == wsfd_pkg::ST_BADUTF || out_status == wsfd_pkg::ST_CTLLONG)
    |-> !out_payload_valid && !out_last_of_frame && out_byte == 8'd0)
    else $error("data or last flag on error or halted item");

  // a non-payload item carries a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_byte == 8'd0)
    else $error("nonzero byte without payload flag");

endmodule

bind websocket_frame_deframer_core wsfd_checker u_wsfd_checker (.*);
